FILE: src/svag_pkg.sv
// ----------------------------------------------------------------------------
// svag_pkg
// Shared types and constants of the strided view address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package svag_pkg;

    localparam int IDX_W     = 32;              // element index width
    localparam int SIZE_W    = 16;              // size and stride width
    localparam int WORD_W    = 32;              // base, count, source index width
    localparam int NUM_W     = 49;              // widest dividend (offset sum)
    localparam int P1_STEPS  = IDX_W;           // outer split steps
    localparam int P2_STEPS  = SIZE_W;          // middle split steps
    localparam int P3_STEPS  = NUM_W;           // wrap reduction steps
    localparam int ADDR_W    = 5;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_MIDDLE_SIZE   = 3'd0;
    localparam logic [2:0] REG_INNER_SIZE    = 3'd1;
    localparam logic [2:0] REG_OUTER_STRIDE  = 3'd2;
    localparam logic [2:0] REG_MIDDLE_STRIDE = 3'd3;
    localparam logic [2:0] REG_INNER_STRIDE  = 3'd4;
    localparam logic [2:0] REG_BASE_OFFSET   = 3'd5;
    localparam logic [2:0] REG_SOURCE_COUNT  = 3'd6;

    // Working set of one restoring division cell.
    typedef struct packed {
        logic [WORD_W-1:0] rem;    // partial remainder, always below the divisor
        logic [NUM_W-1:0]  num;    // dividend bits still to shift in, msb first
        logic [NUM_W-1:0]  quot;   // quotient bits collected so far
        logic [IDX_W-1:0]  keep;   // outer coordinate carried past the split
    } svag_step_t;

endpackage

`default_nettype wire

FILE: src/strided_view_address_generator_core.sv
// ----------------------------------------------------------------------------
// strided_view_address_generator_core
// Maps a linear view index to a wrapped source element index.
// ----------------------------------------------------------------------------
// An accepted input passes through 32 outer split cells, 16 middle split cells,
// 2 multiply/sum stages, 49 wrap reduction cells and the output register
// before its result reaches the output port.
// Throughput: one item per cycle; the pipeline freezes only when both the
// output register and the skid register hold results not yet taken.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none

module strided_view_address_generator_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [svag_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [svag_pkg::IDX_W-1:0]   element_index,
    // Output channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [svag_pkg::WORD_W-1:0]       source_index,
    output logic                              wrapped
);
    import svag_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The plane size (middle times inner) is
    // captured together with a size write so it is ready at once.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] middle_size_reg;
    logic [SIZE_W-1:0] inner_size_reg;
    logic [SIZE_W-1:0] outer_stride_reg;
    logic [SIZE_W-1:0] middle_stride_reg;
    logic [SIZE_W-1:0] inner_stride_reg;
    logic [WORD_W-1:0] base_offset_reg;
    logic [WORD_W-1:0] source_count_reg;
    logic [WORD_W-1:0] plane_reg;
    logic [WORD_W-1:0] plane_next;

    logic              wr_en;
    logic [2:0]        reg_idx;
    logic [SIZE_W-1:0] wr_size;
    logic [SIZE_W-1:0] msz_eff;
    logic [SIZE_W-1:0] isz_eff;
    logic [WORD_W-1:0] mod_eff;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    // A zero size or modulus behaves as one.
    assign wr_size = (pwdata[SIZE_W-1:0] == '0) ? SIZE_W'(1) : pwdata[SIZE_W-1:0];
    assign msz_eff = (middle_size_reg == '0) ? SIZE_W'(1) : middle_size_reg;
    assign isz_eff = (inner_size_reg == '0) ? SIZE_W'(1) : inner_size_reg;
    assign mod_eff = (source_count_reg == '0) ? WORD_W'(1) : source_count_reg;

    always_comb
    begin
        plane_next = plane_reg;
        if (wr_en && reg_idx == REG_MIDDLE_SIZE)
        begin
            plane_next = WORD_W'(wr_size) * WORD_W'(isz_eff);
        end
        else if (wr_en && reg_idx == REG_INNER_SIZE)
        begin
            plane_next = WORD_W'(msz_eff) * WORD_W'(wr_size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            middle_size_reg   <= SIZE_W'(1);
            inner_size_reg    <= SIZE_W'(1);
            outer_stride_reg  <= '0;
            middle_stride_reg <= '0;
            inner_stride_reg  <= SIZE_W'(1);
            base_offset_reg   <= '0;
            source_count_reg  <= WORD_W'(1);
            plane_reg         <= WORD_W'(1);
        end
        else
        begin
            plane_reg <= plane_next;
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_MIDDLE_SIZE:   middle_size_reg   <= pwdata[SIZE_W-1:0];
                    REG_INNER_SIZE:    inner_size_reg    <= pwdata[SIZE_W-1:0];
                    REG_OUTER_STRIDE:  outer_stride_reg  <= pwdata[SIZE_W-1:0];
                    REG_MIDDLE_STRIDE: middle_stride_reg <= pwdata[SIZE_W-1:0];
                    REG_INNER_STRIDE:  inner_stride_reg  <= pwdata[SIZE_W-1:0];
                    REG_BASE_OFFSET:   base_offset_reg   <= pwdata[WORD_W-1:0];
                    REG_SOURCE_COUNT:  source_count_reg  <= pwdata[WORD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIDDLE_SIZE:   prdata = 32'(middle_size_reg);
            REG_INNER_SIZE:    prdata = 32'(inner_size_reg);
            REG_OUTER_STRIDE:  prdata = 32'(outer_stride_reg);
            REG_MIDDLE_STRIDE: prdata = 32'(middle_stride_reg);
            REG_INNER_STRIDE:  prdata = 32'(inner_stride_reg);
            REG_BASE_OFFSET:   prdata = base_offset_reg;
            REG_SOURCE_COUNT:  prdata = source_count_reg;
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline enable. The whole chain moves together; it stops only when
    // the skid register is holding a second result.
    // ------------------------------------------------------------------
    logic skid_full_reg;
    logic en;

    assign en       = !skid_full_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Outer split: element_index divided by the plane size, one quotient
    // bit per cell. The index enters left-aligned in the dividend field.
    // ------------------------------------------------------------------
    logic       v1 [0:P1_STEPS];
    svag_step_t d1 [0:P1_STEPS];

    always_comb
    begin
        v1[0]      = in_valid;
        d1[0].rem  = '0;
        d1[0].num  = {element_index, (NUM_W-IDX_W)'(0)};
        d1[0].quot = '0;
        d1[0].keep = '0;
    end

    for (genvar i = 0; i < P1_STEPS; i++)
    begin : g_outer
        svag_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .den       (plane_reg),
            .in_valid  (v1[i]),
            .in_d      (d1[i]),
            .out_valid (v1[i+1]),
            .out_d     (d1[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Middle split: the remainder is below 2^16 times the inner size, so
    // its upper half seeds the partial remainder and 16 steps suffice.
    // ------------------------------------------------------------------
    logic       v2 [0:P2_STEPS];
    svag_step_t d2 [0:P2_STEPS];

    always_comb
    begin
        v2[0]      = v1[P1_STEPS];
        d2[0].rem  = WORD_W'(d1[P1_STEPS].rem[WORD_W-1:SIZE_W]);
        d2[0].num  = {d1[P1_STEPS].rem[SIZE_W-1:0], (NUM_W-SIZE_W)'(0)};
        d2[0].quot = '0;
        d2[0].keep = d1[P1_STEPS].quot[IDX_W-1:0];
    end

    for (genvar i = 0; i < P2_STEPS; i++)
    begin : g_middle
        svag_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .den       (WORD_W'(isz_eff)),
            .in_valid  (v2[i]),
            .in_d      (d2[i]),
            .out_valid (v2[i+1]),
            .out_d     (d2[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Coordinates times strides plus the base offset.
    // ------------------------------------------------------------------
    logic             sum_valid;
    logic [NUM_W-1:0] offset;

    svag_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (v2[P2_STEPS]),
        .outer         (d2[P2_STEPS].keep),
        .middle        (d2[P2_STEPS].quot[SIZE_W-1:0]),
        .inner         (d2[P2_STEPS].rem[SIZE_W-1:0]),
        .outer_stride  (outer_stride_reg),
        .middle_stride (middle_stride_reg),
        .inner_stride  (inner_stride_reg),
        .base_offset   (base_offset_reg),
        .out_valid     (sum_valid),
        .offset        (offset)
    );

    // ------------------------------------------------------------------
    // Wrap reduction: offset modulo source_count. A nonzero quotient means
    // the offset reached the modulus, which is exactly the wrapped flag.
    // ------------------------------------------------------------------
    logic       v3 [0:P3_STEPS];
    svag_step_t d3 [0:P3_STEPS];

    always_comb
    begin
        v3[0]      = sum_valid;
        d3[0].rem  = '0;
        d3[0].num  = offset;
        d3[0].quot = '0;
        d3[0].keep = '0;
    end

    for (genvar i = 0; i < P3_STEPS; i++)
    begin : g_wrap
        svag_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .den       (mod_eff),
            .in_valid  (v3[i]),
            .in_d      (d3[i]),
            .out_valid (v3[i+1]),
            .out_d     (d3[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register with a skid register behind it. While the skid is
    // empty the chain keeps moving; a result that arrives while the output
    // is stalled is parked in the skid and the chain then holds.
    // ------------------------------------------------------------------
    logic              res_valid;
    logic [WORD_W-1:0] res_index;
    logic              res_wrap;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_index_reg;
    logic              out_wrap_reg;
    logic [WORD_W-1:0] skid_index_reg;
    logic              skid_wrap_reg;

    assign res_valid = v3[P3_STEPS];
    assign res_index = d3[P3_STEPS].rem;
    assign res_wrap  = |d3[P3_STEPS].quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_ready)
            begin
                out_index_reg <= skid_index_reg;
                out_wrap_reg  <= skid_wrap_reg;
            end
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_index_reg <= res_index;
            out_wrap_reg  <= res_wrap;
        end
        else
        begin
            skid_index_reg <= res_index;
            skid_wrap_reg  <= res_wrap;
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_index = out_index_reg;
    assign wrapped      = out_wrap_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A parked result always sits behind a visible one.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a result while the output is empty");

    // The skid only fills when the output was stalled.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid filled without an output stall");

    // The remainder leaving the chain is always below the modulus.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_index < mod_eff))
        else $error("reduced index not below source_count");

    // A result without the wrap flag came from a zero quotient.
    a_nowrap_small: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_wrap) |-> (d3[P3_STEPS].quot == '0))
        else $error("wrap flag disagrees with the quotient");

endmodule

`default_nettype wire

FILE: src/svag_cell.sv
// ----------------------------------------------------------------------------
// svag_cell
// One restoring division step: shifts one dividend bit into the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module svag_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic [svag_pkg::WORD_W-1:0] den,
    input  wire logic                       in_valid,
    input  wire svag_pkg::svag_step_t       in_d,
    output logic                            out_valid,
    output svag_pkg::svag_step_t            out_d
);
    import svag_pkg::*;

    logic                valid_reg;
    svag_step_t          d_reg;
    svag_step_t          d_next;
    logic [WORD_W:0]     trial;
    logic [WORD_W:0]     diff;
    logic                ge;

    always_comb
    begin
        trial  = {in_d.rem, in_d.num[NUM_W-1]};
        diff   = trial - {1'b0, den};
        ge     = (trial >= {1'b0, den});
        d_next = in_d;
        d_next.rem  = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        d_next.num  = {in_d.num[NUM_W-2:0], 1'b0};
        d_next.quot = {in_d.quot[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_d     = d_reg;

endmodule

`default_nettype wire

FILE: src/svag_mac.sv
// ----------------------------------------------------------------------------
// svag_mac
// Two-stage stride multiply and offset sum.
// ----------------------------------------------------------------------------
`default_nettype none

module svag_mac (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [svag_pkg::IDX_W-1:0]  outer,
    input  wire logic [svag_pkg::SIZE_W-1:0] middle,
    input  wire logic [svag_pkg::SIZE_W-1:0] inner,
    input  wire logic [svag_pkg::SIZE_W-1:0] outer_stride,
    input  wire logic [svag_pkg::SIZE_W-1:0] middle_stride,
    input  wire logic [svag_pkg::SIZE_W-1:0] inner_stride,
    input  wire logic [svag_pkg::WORD_W-1:0] base_offset,
    output logic                             out_valid,
    output logic [svag_pkg::NUM_W-1:0]       offset
);
    import svag_pkg::*;

    localparam int P1_W = IDX_W + SIZE_W;
    localparam int P2_W = 2 * SIZE_W;

    logic              v1_reg;
    logic              v2_reg;
    logic [P1_W-1:0]   p1_reg;
    logic [P2_W-1:0]   p2_reg;
    logic [P2_W-1:0]   p3_reg;
    logic [NUM_W-1:0]  sum_reg;
    logic [NUM_W-1:0]  sum_next;

    // The sum is below 2^49, so it never loses a carry.
    assign sum_next = NUM_W'(base_offset) + NUM_W'(p1_reg)
                    + NUM_W'(p2_reg) + NUM_W'(p3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= P1_W'(outer) * P1_W'(outer_stride);
            p2_reg  <= P2_W'(middle) * P2_W'(middle_stride);
            p3_reg  <= P2_W'(inner) * P2_W'(inner_stride);
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v2_reg;
    assign offset    = sum_reg;

endmodule

`default_nettype wire

FILE: sim/svag_checker.sv
// ----------------------------------------------------------------------------
// svag_checker
// Watches both channels of the strided view address generator and the
// configuration port, predicts each source index and compares the results.
// ----------------------------------------------------------------------------
module svag_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [31:0] element_index,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] source_index,
    input  wire logic        wrapped,
    output int               fail_count,
    output int               pending,
    output int               wrap_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import svag_pkg::*;

    typedef struct packed {
        logic [31:0] src;
        logic        wrp;
    } gather_addr_t;

    logic [15:0] msize, isize, ostride, mstride, istride;
    logic [31:0] base, count;
    gather_addr_t addr_q[$];

    function automatic gather_addr_t map_index(logic [31:0] idx);
        logic [63:0] ms, is, md, plane, rest, oc, mc, off;
        gather_addr_t r;
        ms = (msize == 0) ? 64'd1 : 64'(msize);
        is = (isize == 0) ? 64'd1 : 64'(isize);
        md = (count == 0) ? 64'd1 : 64'(count);
        plane = ms * is;
        rest = 64'(idx);
        oc = rest / plane;
        rest = rest - oc * plane;
        mc = rest / is;
        rest = rest - mc * is;
        off = 64'(base) + oc * ostride + mc * mstride + rest * istride;
        r.wrp = (off >= md);
        if (r.wrp)
            off = off % md;
        r.src = off[31:0];
        return r;
    endfunction

    assign pending = addr_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize <= 16'd1; isize <= 16'd1; ostride <= '0; mstride <= '0;
            istride <= 16'd1; base <= '0; count <= 32'd1;
            fail_count <= 0;
            wrap_seen <= 0;
            addr_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_MIDDLE_SIZE:   msize   <= pwdata[15:0];
                    REG_INNER_SIZE:    isize   <= pwdata[15:0];
                    REG_OUTER_STRIDE:  ostride <= pwdata[15:0];
                    REG_MIDDLE_STRIDE: mstride <= pwdata[15:0];
                    REG_INNER_STRIDE:  istride <= pwdata[15:0];
                    REG_BASE_OFFSET:   base    <= pwdata;
                    REG_SOURCE_COUNT:  count   <= pwdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                addr_q.push_back(map_index(element_index));
            if (out_valid && out_ready)
            begin
                if (addr_q.size() == 0)
                begin
                    $error("unexpected result source_index=%h", source_index);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    gather_addr_t e;
                    int errs;
                    errs = 0;
                    e = addr_q[0];
                    addr_q.delete(0);
                    if (wrapped) wrap_seen <= wrap_seen + 1;
                    if (e.src !== source_index)
                    begin
                        $error("source_index expected %h got %h", e.src, source_index);
                        errs++;
                    end
                    if (e.wrp !== wrapped)
                    begin
                        $error("wrapped expected %b got %b", e.wrp, wrapped);
                        errs++;
                    end
                    fail_count <= fail_count + errs;
                end
            end
        end
    end
endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the strided view address generator through several view shapes,
// strides, offsets and wrap moduli, with bursty input and stalling output.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import svag_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] element_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] source_index;
    logic        wrapped;

    int fail_count, pending, wrap_seen;
    int items_sent = 0;
    int idle_cycles = 0;
    int settings_run = 0;
    bit stim_done = 1'b0;

    // The pipeline is about 100 stages deep, so an idle stretch as long as
    // WATCHDOG can only mean a hang.
    localparam int WATCHDOG = 5000;
    localparam int DRAIN    = 150;
    // An index past the end of the register list.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    strided_view_address_generator_core dut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .in_valid, .in_ready, .element_index,
        .out_valid, .out_ready, .source_index, .wrapped
    );

    svag_checker chk (
        .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .in_valid, .in_ready, .element_index,
        .out_valid, .out_ready, .source_index, .wrapped,
        .fail_count, .pending, .wrap_seen
    );

    // The receiver stalls on a pattern of its own: a mode picked now and
    // then decides whether it always accepts, stalls lightly or heavily.
    int stall_mode = 0;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // A run of cycles with no handshake at all ends the test as a hang.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("timeout with %0d results outstanding", pending);
            $display("[strided_view_address_generator_core] ERROR");
            $finish;
        end
    end

    // One APB write: the setup phase, then the access phase.
    task automatic write_reg(logic [2:0] reg_idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {reg_idx, 2'b00}; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Every item yields a result, so an empty prediction queue means idle.
    task automatic wait_drained();
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_view(logic [15:0] ms, logic [15:0] is, logic [15:0] os,
                            logic [15:0] mst, logic [15:0] ist,
                            logic [31:0] base, logic [31:0] cnt);
        wait_drained();
        // The upper half of a size word is ignored, so it carries noise.
        write_reg(REG_MIDDLE_SIZE, {16'($urandom), ms});
        write_reg(REG_INNER_SIZE, {16'($urandom), is});
        write_reg(REG_OUTER_STRIDE, 32'(os));
        write_reg(REG_MIDDLE_STRIDE, 32'(mst));
        write_reg(REG_INNER_STRIDE, 32'(ist));
        write_reg(REG_BASE_OFFSET, base);
        write_reg(REG_SOURCE_COUNT, cnt);
        // An index beyond the register list must be ignored.
        write_reg(REG_UNUSED, $urandom);
        settings_run++;
    endtask

    // Holds valid until the item is taken; a following item keeps valid high.
    task automatic send_index(logic [31:0] idx);
        in_valid <= 1'b1;
        element_index <= idx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic end_burst();
        int gap;
        in_valid <= 1'b0;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_index(int mode);
        case (mode)
            0:       return $urandom;
            1:       return $urandom_range(0, 4095);
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: return $urandom_range(0, 1 << $urandom_range(0, 31));
        endcase
    endfunction

    task automatic random_phase(int count);
        int left, burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            if (burst > left) burst = left;
            repeat (burst) send_index(rand_index($urandom_range(0, 3)));
            left -= burst;
            end_burst();
        end
    endtask

    function automatic logic [15:0] rand_size();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: inner stride 1 and a modulus of 1; with unit sizes and a
        // zero outer stride every index maps to offset zero and none wraps.
        send_index(32'd0);
        send_index(32'd5);
        send_index(32'hFFFF_FFFF);
        end_burst();

        // Largest sizes and strides, largest base, with the exact sum well
        // past 32 bits before the wrap.
        set_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_index(32'd0);
        send_index(32'hFFFF_FFFF);
        send_index(32'hFFFE_0001);
        send_index(32'h0000_FFFF);
        end_burst();

        // Zero sizes count as one and a zero modulus as one.
        set_view(16'd0, 16'd0, 16'd3, 16'd5, 16'd7, 32'd0, 32'd0);
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'h8000_0000);
        end_burst();

        // A small 3x4 view over a source of 1000, with the offset below the
        // modulus and exactly at it.
        set_view(16'd3, 16'd4, 16'd100, 16'd10, 16'd1, 32'd0, 32'd1000);
        for (int i = 0; i < 13; i++)
            send_index(32'(i));
        send_index(32'd119);
        send_index(32'd120);
        end_burst();

        // Random settings, each with its own batch of items.
        while (items_sent < 1800)
        begin
            set_view(rand_size(), rand_size(), rand_size(), rand_size(), rand_size(),
                     rand_word(), rand_word());
            random_phase($urandom_range(60, 160));
        end

        // Back to the small extremes at the end.
        set_view(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 32'd0, 32'd1);
        random_phase(20);
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("%0d items mapped under %0d view settings, %0d results wrapped",
                 items_sent, settings_run, wrap_seen);
        if (fail_count == 0 && pending == 0)
            $display("[strided_view_address_generator_core] OK");
        else
            $display("[strided_view_address_generator_core] ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
src/svag_pkg.sv
src/svag_cell.sv
src/svag_mac.sv
src/strided_view_address_generator_core.sv
sim/svag_checker.sv
sim/testbench.sv
